>>> hw/rtl/b64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the sextet-to-character mapping for the
// base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int CHAR_W      = 7;
    localparam int SEXTET_W    = 6;
    localparam int BYTE_W      = 8;
    localparam int JOB_CHARS   = 4;
    localparam int JOB_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    localparam logic [SEXTET_W-1:0] SEXTET_LC_BASE  = 6'd26;
    localparam logic [SEXTET_W-1:0] SEXTET_DIG_BASE = 6'd52;
    localparam logic [SEXTET_W-1:0] SEXTET_PLUS     = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_SLASH    = 6'd63;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    // characters of one input byte, handed from front to back
    typedef struct packed {
        logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
        logic [JOB_IDX_W-1:0]             last_idx;
        logic                             final_msg;
    } job_t;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] c;
        if (v < SEXTET_LC_BASE) begin
            c = CHAR_UC_A + {1'b0, v};
        end
        else if (v < SEXTET_DIG_BASE) begin
            c = CHAR_LC_A + {1'b0, v - SEXTET_LC_BASE};
        end
        else if (v < SEXTET_PLUS) begin
            c = CHAR_ZERO + {1'b0, v - SEXTET_DIG_BASE};
        end
        else if (v == SEXTET_PLUS) begin
            c = CHAR_PLUS;
        end
        else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/b64enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts raw bytes, tracks group position and leftover bits, and turns each
// byte into a job of one to four characters.
// ----------------------------------------------------------------------------
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              final_byte,
    input  logic              queue_full,
    output logic              push,
    output job_t              job
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  carry_reg, carry_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        job           = '0;
        job.final_msg = final_byte;
        phase_next    = phase_reg;
        carry_next    = carry_reg;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                job.chars[0] = sextet_char({carry_reg[1:0], data_byte[7:4]});
                job.chars[1] = sextet_char({data_byte[3:0], 2'b00});
                job.chars[2] = CHAR_PAD;
                job.last_idx = final_byte ? 2'd2 : 2'd0;
                carry_next   = data_byte[3:0];
                phase_next   = PHASE_THIRD;
            end
            PHASE_THIRD:
            begin
                job.chars[0] = sextet_char({carry_reg, data_byte[7:6]});
                job.chars[1] = sextet_char(data_byte[5:0]);
                job.last_idx = 2'd1;
                carry_next   = 4'd0;
                phase_next   = PHASE_FIRST;
            end
            default:
            begin
                job.chars[0] = sextet_char(data_byte[7:2]);
                job.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
                job.chars[2] = CHAR_PAD;
                job.chars[3] = CHAR_PAD;
                job.last_idx = final_byte ? 2'd3 : 2'd0;
                carry_next   = {2'b00, data_byte[1:0]};
                phase_next   = PHASE_SECOND;
            end
        endcase
        if (final_byte) begin
            phase_next = PHASE_FIRST;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= 4'd0;
        end
        else if (push) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

>>> hw/rtl/b64enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/b64enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_back
// Takes jobs from the queue and sends their characters one per cycle, unless
// out_ready stalls them, through a registered output stage.
// ----------------------------------------------------------------------------
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_avail,
    input  job_t              head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              final_char
);

    job_t                 cur_reg;
    logic                 cur_valid_reg;
    logic [JOB_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;
    logic                 advance;
    logic                 send;
    logic                 at_end;

    assign advance = !out_valid_reg || out_ready;
    assign send    = advance && cur_valid_reg;
    assign at_end  = (idx_reg == cur_reg.last_idx);
    assign pop     = job_avail && (!cur_valid_reg || (send && at_end));

    assign out_valid  = out_valid_reg;
    assign out_char   = char_reg;
    assign final_char = last_reg;

    always_ff @(posedge clk)
    begin
        if (pop) begin
            cur_reg <= head_job;
        end
        if (send) begin
            char_reg <= cur_reg.chars[idx_reg];
            last_reg <= cur_reg.final_msg && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (advance) begin
                out_valid_reg <= cur_valid_reg;
            end
            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (send) begin
                if (at_end) begin
                    cur_valid_reg <= 1'b0;
                end
                else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

>>> hw/rtl/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet, no line wrapping.
//
//   channel  dir  contents                               marker
//   s_*      in   tdata[7:0] data_byte                   tlast final_byte
//   m_*      out  tdata[6:0] out_char, tdata[7] zero     tlast final_char
//
// A byte is taken every cycle while the two-entry job queue has room.
// Characters leave one per cycle from the output register unless the output
// stalls; a body byte yields one character as first or second of a group and
// two as third, and a final byte four as first, three as second, two as third.
// Characters pass the queue entry, current-job register and output register.
// Reset clears group position, carried bits, queue and output valid.
// Input stalls only when the queue is full; output stalls back up the queue.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char, zero
    output logic       m_tlast
);

    logic              push;
    logic              pop;
    logic              full;
    logic              not_empty;
    job_t              push_job;
    job_t              head_job;
    logic [CHAR_W-1:0] out_char;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .queue_full (full),
        .push       (push),
        .job        (push_job)
    );

    b64enc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    b64enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_avail  (not_empty),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .final_char (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

>>> tb/sv/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking testbench for the base64 stream encoder. A queue of raw bytes,
// grouped into messages, feeds a stream driver with random gaps. Each accepted
// byte runs through a local encoder model that queues the expected characters.
// A monitor stalls the output side at random and checks every character and its
// final marker against that queue. Directed messages come first, then random ones.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;
    import b64enc_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 250000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_BYTES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } raw_byte_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } b64_char_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    raw_byte_t  byte_queue[$];
    b64_char_t  expected_chars[$];
    raw_byte_t  next_byte;
    b64_char_t  want;

    phase_t     group_pos = PHASE_FIRST;
    logic [3:0] leftover  = 4'h0;

    int         error_count = 0;
    int         cycle_count = 0;
    int         in_gap      = 0;
    int         in_calm     = 0;
    int         out_stall   = 0;
    int         out_calm    = 0;

    base64_stream_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [SEXTET_W-1:0] v);
        string abc;
        byte   c;
        abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        c = abc[v];
        return c[CHAR_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic expect_char(input logic [CHAR_W-1:0] ch, input logic fin);
        b64_char_t e;
        e.ch  = ch;
        e.fin = fin;
        expected_chars.push_back(e);
    endtask

    // encoder model: updates group position and leftover bits
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        case (group_pos)
            PHASE_SECOND:
            begin
                expect_char(sextet_to_ascii({leftover[1:0], b[7:4]}), 1'b0);
                leftover  = b[3:0];
                group_pos = PHASE_THIRD;
                if (fin)
                begin
                    expect_char(sextet_to_ascii({leftover, 2'b00}), 1'b0);
                    expect_char(CHAR_PAD, 1'b1);
                end
            end
            PHASE_THIRD:
            begin
                expect_char(sextet_to_ascii({leftover, b[7:6]}), 1'b0);
                expect_char(sextet_to_ascii(b[5:0]), fin);
                leftover  = 4'h0;
                group_pos = PHASE_FIRST;
            end
            default:
            begin
                expect_char(sextet_to_ascii(b[7:2]), 1'b0);
                leftover  = {2'b00, b[1:0]};
                group_pos = PHASE_SECOND;
                if (fin)
                begin
                    expect_char(sextet_to_ascii({leftover[1:0], 4'h0}), 1'b0);
                    expect_char(CHAR_PAD, 1'b0);
                    expect_char(CHAR_PAD, 1'b1);
                end
            end
        endcase
        if (fin)
        begin
            group_pos = PHASE_FIRST;
            leftover  = 4'h0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        raw_byte_t r;
        r.data = b;
        r.fin  = fin;
        byte_queue.push_back(r);
    endtask

    task automatic queue_message(input int len);
        logic [7:0] b;
        int         k;
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            queue_byte(b, k == len - 1);
        end
    endtask

    // input side driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (in_calm > 0)
                in_calm--;
            else if ($urandom_range(0, 49) == 0)
                in_calm = $urandom_range(20, 50);
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                next_byte = byte_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.data;
                s_tlast  <= next_byte.fin;
                in_gap   = (in_calm > 0) ? 0 : pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected transaction: out_char %h final_char %b",
                           m_tdata[CHAR_W-1:0], m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.ch)
                    begin
                        $error("out_char expected %h actual %h", want.ch,
                               m_tdata[CHAR_W-1:0]);
                        error_count++;
                    end
                    if (m_tlast !== want.fin)
                    begin
                        $error("final_char expected %b actual %b", want.fin, m_tlast);
                        error_count++;
                    end
                    if (m_tdata[7] !== 1'b0)
                    begin
                        $error("tdata pad expected %b actual %b", 1'b0, m_tdata[7]);
                        error_count++;
                    end
                end
            end
            if (out_calm > 0)
                out_calm--;
            else if ($urandom_range(0, 99) == 0)
                out_calm = $urandom_range(20, 60);
            if (out_stall > 0)
            begin
                out_stall--;
                m_tready <= 1'b0;
            end
            else if (out_calm == 0 && $urandom_range(0, 99) < 25)
            begin
                out_stall = pick_gap();
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int queued;

        // single-byte messages, padded with two pad characters
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        // two-byte message, one pad character
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        // full groups at the extremes and the two symbol characters
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBE, 1'b1);
        // message running into a second group
        queue_byte(8'h4D, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h6E, 1'b0);
        queue_byte(8'h4D, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'h05, 1'b1);

        queued = 0;
        while (queued < RANDOM_BYTES)
        begin
            int r;
            int len;
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 95)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(21, 40);
            queue_message(len);
            queued += len;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_queue.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/b64enc_pkg.sv
hw/rtl/b64enc_front.sv
hw/rtl/b64enc_queue.sv
hw/rtl/b64enc_back.sv
hw/rtl/base64_stream_encoder.sv
tb/sv/tb_base64_stream_encoder.sv
